[hdl/lidar_range_to_point_converter_macros.svh]
// assertion macros for the lidar point converter top level
`ifndef LIDAR_RANGE_TO_POINT_CONVERTER_MACROS_SVH
`define LIDAR_RANGE_TO_POINT_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LRPC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lrpc_pkg.sv]
// types and constants of the lidar point converter
`default_nettype none
package lrpc_pkg;

  typedef enum logic [2:0] {
    REG_H_ANGLE_MIN   = 3'd0,
    REG_H_ANGLE_STEP  = 3'd1,
    REG_V_ANGLE_MIN   = 3'd2,
    REG_V_ANGLE_STEP  = 3'd3,
    REG_MIN_RANGE     = 3'd4,
    REG_MAX_RANGE     = 3'd5,
    REG_INTEN_FLOOR   = 3'd6
  } cfg_reg_t;

  // pi/2 scaled so that (t * PI_Q32) >> 17 is the quarter-wave argument in Q2.30
  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam int TERMS = 7;
  localparam int CELL_LAT = 3;
  localparam int RECIP_SHIFT = 40;
  // front end 2, cells, magnitude stage 1
  localparam int SINE_LAT = 2 + TERMS * CELL_LAT + 1;

  // data handed from one taylor cell to the next
  typedef struct packed {
    logic [31:0]        x2;
    logic [30:0]        term;
    logic signed [33:0] sum;
    logic               neg;
  } taylor_t;

  // per-point payload riding beside the sine units
  typedef struct packed {
    logic        keep;
    logic [23:0] range_value;
    logic [15:0] intensity;
    logic [6:0]  ring;
  } item_t;

endpackage
`default_nettype wire

[hdl/lrpc_taylor_cell.sv]
// one taylor term cell: multiply by x^2, exact divide by a constant, accumulate
`default_nettype none
module lrpc_taylor_cell
  import lrpc_pkg::*;
#(
  parameter int K = 1
) (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire taylor_t cell_i,
  output taylor_t      cell_o
);

  localparam longint unsigned D = 64'((2 * K) * (2 * K + 1));
  localparam longint unsigned M = (64'd1 << RECIP_SHIFT) / D;
  localparam logic [37:0] M_W = 38'(M);
  localparam logic [18:0] M_HI = M_W[37:19];
  localparam logic [18:0] M_LO = M_W[18:0];
  localparam logic [7:0]  D_W = 8'(D);
  localparam bit SUBTRACT = (K % 2) == 1;

  logic [62:0] prod1;
  logic [32:0] n1_r;
  logic [31:0] x2_1_r;
  logic signed [33:0] sum_1_r;
  logic neg_1_r;

  logic [51:0] ph, pl;
  logic [70:0] prod2;
  logic [30:0] qe2_r;
  logic [32:0] n2_r;
  logic [31:0] x2_2_r;
  logic signed [33:0] sum_2_r;
  logic neg_2_r;

  logic [33:0] qd, rem;
  logic [30:0] q;
  logic signed [33:0] qs;

  // stage 1: term * x^2, scaled back to Q2.30
  assign prod1 = 63'(cell_i.term) * 63'(cell_i.x2);

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r    <= prod1[62:30];
      x2_1_r  <= cell_i.x2;
      sum_1_r <= cell_i.sum;
      neg_1_r <= cell_i.neg;
    end
  end

  // stage 2: quotient estimate through the reciprocal, two partial products
  assign ph    = 52'(n1_r) * 52'(M_HI);
  assign pl    = 52'(n1_r) * 52'(M_LO);
  assign prod2 = (71'(ph) << 19) + 71'(pl);

  always_ff @(posedge clk) begin
    if (en) begin
      qe2_r   <= prod2[70:40];
      n2_r    <= n1_r;
      x2_2_r  <= x2_1_r;
      sum_2_r <= sum_1_r;
      neg_2_r <= neg_1_r;
    end
  end

  // stage 3: estimate is exact or one low, fix it and accumulate
  always_comb begin
    qd  = 34'(qe2_r) * 34'(D_W);
    rem = 34'(n2_r) - qd;
    q   = (rem >= 34'(D_W)) ? qe2_r + 31'd1 : qe2_r;
    qs  = $signed({3'b000, q});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_o.x2   <= x2_2_r;
      cell_o.term <= q;
      cell_o.sum  <= SUBTRACT ? sum_2_r - qs : sum_2_r + qs;
      cell_o.neg  <= neg_2_r;
    end
  end

endmodule
`default_nettype wire

[hdl/lrpc_sine.sv]
// pipelined Q1.15 sine of a 16-bit binary angle, chain of taylor cells
`default_nettype none
module lrpc_sine
  import lrpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] angle,
  output logic signed [15:0] sine
);

  logic [1:0]  quad;
  logic [14:0] t;
  logic [48:0] xp;
  logic [30:0] x1_r;
  logic        neg1_r;
  logic [61:0] x2p;
  taylor_t     head_r;
  taylor_t     chain [0:TERMS];

  logic signed [34:0] rnd;
  logic [19:0] mag_full;
  logic [14:0] mag;

  // fold into the first quadrant
  always_comb begin
    quad = angle[15:14];
    t    = quad[0] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    xp   = 49'(t) * 49'(PI_Q32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= xp[47:17];
      neg1_r <= quad[1];
    end
  end

  assign x2p = 62'(x1_r) * 62'(x1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      head_r.x2   <= x2p[61:30];
      head_r.term <= x1_r;
      head_r.sum  <= $signed({3'b000, x1_r});
      head_r.neg  <= neg1_r;
    end
  end

  assign chain[0] = head_r;

  for (genvar k = 1; k <= TERMS; k++) begin : g_cell
    lrpc_taylor_cell #(.K(k)) u_cell (
      .clk    (clk),
      .en     (en),
      .cell_i (chain[k-1]),
      .cell_o (chain[k])
    );
  end

  // clamp, round to Q1.15, saturate, apply quadrant sign
  always_comb begin
    rnd      = chain[TERMS].sum[33] ? 35'sd16384 : 35'(chain[TERMS].sum) + 35'sd16384;
    mag_full = rnd[34:15];
    mag      = (mag_full > 20'd32767) ? 15'h7fff : mag_full[14:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= chain[TERMS].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule
`default_nettype wire

[hdl/lidar_range_to_point_converter.sv]
// top level: lidar return to cartesian point converter
`default_nettype none
`include "lidar_range_to_point_converter_macros.svh"
// Takes one lidar return word per cycle and gives one point word per cycle
// while out_stall does not hold the output word. The accepting edge registers
// the yaw and pitch angles, four parallel sine units follow (each a front end,
// a chain of seven taylor cells of three stages each, and a rounding stage),
// and the range scaling stages scale by range and register the output. The
// whole pipeline advances together and freezes while the output word is held
// by out_stall, so in_stall is simply that hold. A dropped point (out of range
// window, below the intensity floor or index not below COLUMNS or RINGS) comes
// out with keep low and all other fields zero. Configuration writes are always
// taken (cfg_ready is tied high); unknown indexes are ignored.
module lidar_range_to_point_converter
  import lrpc_pkg::*;
#(
  parameter int COLUMNS = 2048,
  parameter int RINGS   = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] in_range_value,
  input  wire logic [15:0] in_intensity_in,
  input  wire logic [10:0] in_column_index,
  input  wire logic [6:0]  in_ring_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_keep,
  output logic signed [24:0] out_x_pos,
  output logic signed [24:0] out_y_pos,
  output logic signed [24:0] out_z_pos,
  output logic [15:0]      out_intensity_out,
  output logic [6:0]       out_ring_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int VLEN = SINE_LAT + 3;

  // configuration registers
  logic [15:0] h_angle_min_r, h_angle_step_r, v_angle_min_r, v_angle_step_r;
  logic [23:0] min_range_r, max_range_r;
  logic [15:0] inten_floor_r;

  logic adv;
  logic accept;
  logic [VLEN-1:0] v_r;
  logic out_valid_r;

  // stage 0
  logic [26:0] yaw_prod;
  logic [22:0] pitch_prod;
  logic [15:0] yaw_nxt, pitch_nxt;
  logic        keep_nxt;
  logic [15:0] yaw_r, pitch_r;
  item_t       s0_r;
  item_t       dly_r [0:SINE_LAT-1];

  logic signed [15:0] sp, cp, sy, cy;

  // range scaling stages
  logic signed [40:0] rc_nxt, zp_nxt;
  logic signed [40:0] rc_r, zp_r;
  logic signed [15:0] cy_r, sy_r;
  item_t              m1_r;
  logic signed [56:0] xp_nxt, yp_nxt;
  logic signed [56:0] xp_r, yp_r;
  logic signed [40:0] zr;
  logic signed [24:0] z_r;
  item_t              m2_r;
  logic signed [56:0] xr, yr;

  // the whole pipe moves unless a finished word is being held
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_angle_min_r   <= '0;
      h_angle_step_r  <= '0;
      v_angle_min_r   <= '0;
      v_angle_step_r  <= '0;
      min_range_r     <= '0;
      max_range_r     <= 24'hffffff;
      inten_floor_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_H_ANGLE_MIN:   h_angle_min_r   <= cfg_data[15:0];
        REG_H_ANGLE_STEP:  h_angle_step_r  <= cfg_data[15:0];
        REG_V_ANGLE_MIN:   v_angle_min_r   <= cfg_data[15:0];
        REG_V_ANGLE_STEP:  v_angle_step_r  <= cfg_data[15:0];
        REG_MIN_RANGE:     min_range_r     <= cfg_data;
        REG_MAX_RANGE:     max_range_r     <= cfg_data;
        REG_INTEN_FLOOR:   inten_floor_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // angles wrap modulo one turn, so only the low 16 bits of each product matter
  always_comb begin
    yaw_prod   = 27'(h_angle_step_r) * 27'(in_column_index);
    pitch_prod = 23'(v_angle_step_r) * 23'(in_ring_index);
    yaw_nxt    = h_angle_min_r + yaw_prod[15:0];
    pitch_nxt  = v_angle_min_r + pitch_prod[15:0];
    keep_nxt   = (min_range_r < in_range_value) && (in_range_value < max_range_r) &&
                 (in_intensity_in >= inten_floor_r) &&
                 (int'(in_column_index) < COLUMNS) && (int'(in_ring_index) < RINGS);
  end

  // valid bits for every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[VLEN-2:0], accept};
      out_valid_r <= v_r[VLEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_r             <= yaw_nxt;
      pitch_r           <= pitch_nxt;
      s0_r.keep         <= keep_nxt;
      s0_r.range_value  <= in_range_value;
      s0_r.intensity    <= in_intensity_in;
      s0_r.ring         <= in_ring_index;
      dly_r[0]          <= s0_r;
      for (int i = 1; i < SINE_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // cosine is sine a quarter turn ahead
  lrpc_sine u_sin_pitch (.clk(clk), .en(adv), .angle(pitch_r),            .sine(sp));
  lrpc_sine u_cos_pitch (.clk(clk), .en(adv), .angle(pitch_r + 16'h4000), .sine(cp));
  lrpc_sine u_sin_yaw   (.clk(clk), .en(adv), .angle(yaw_r),              .sine(sy));
  lrpc_sine u_cos_yaw   (.clk(clk), .en(adv), .angle(yaw_r + 16'h4000),   .sine(cy));

  // r*cos(p) and r*sin(p)
  always_comb begin
    rc_nxt = $signed({1'b0, dly_r[SINE_LAT-1].range_value}) * cp;
    zp_nxt = $signed({1'b0, dly_r[SINE_LAT-1].range_value}) * sp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc_r <= rc_nxt;
      zp_r <= zp_nxt;
      cy_r <= cy;
      sy_r <= sy;
      m1_r <= dly_r[SINE_LAT-1];
    end
  end

  // horizontal products; z rounds half up here
  always_comb begin
    xp_nxt = rc_r * cy_r;
    yp_nxt = rc_r * sy_r;
    zr     = zp_r + 41'sd16384;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xp_r <= xp_nxt;
      yp_r <= yp_nxt;
      z_r  <= zr[39:15];
      m2_r <= m1_r;
    end
  end

  always_comb begin
    xr = xp_r + 57'sd536870912;
    yr = yp_r + 57'sd536870912;
  end

  // output word; a dropped point carries zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      out_keep          <= m2_r.keep;
      out_x_pos         <= m2_r.keep ? xr[54:30] : '0;
      out_y_pos         <= m2_r.keep ? yr[54:30] : '0;
      out_z_pos         <= m2_r.keep ? z_r : '0;
      out_intensity_out <= m2_r.keep ? m2_r.intensity : '0;
      out_ring_out      <= m2_r.keep ? m2_r.ring : '0;
    end
  end

  `LRPC_ASSERT(a_drop_zero, out_valid && !out_keep,
    out_x_pos == 0 && out_y_pos == 0 && out_z_pos == 0 &&
    out_intensity_out == 0 && out_ring_out == 0, "dropped point has nonzero fields")
  `LRPC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_r[0],
    "accepted word did not enter the pipe")
  `LRPC_ASSERT_NEXT(a_hold_freezes, out_valid && out_stall, $stable(v_r) && out_valid,
    "pipe moved while output held")
  `LRPC_ASSERT(a_kept_ring, out_valid && out_keep, int'(out_ring_out) < RINGS,
    "kept point with ring beyond RINGS")

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking bench for the lidar return to point converter
module tb_top;
  import lrpc_pkg::*;

  // column and ring counts of the block at its default parameters
  localparam int NUM_COLUMNS = 2048;
  localparam int NUM_RINGS   = 128;
  // depth of the top level valid pipe, plus margin
  localparam int PIPE_DEPTH  = 27;
  localparam int DRAIN_WAIT  = PIPE_DEPTH + 10;
  // register index that the block does not implement
  localparam logic [2:0] UNKNOWN_REG = 3'd7;

  logic clk;
  logic rst_n;

  logic        in_valid;
  logic        in_stall;
  logic [23:0] in_range_value;
  logic [15:0] in_intensity_in;
  logic [10:0] in_column_index;
  logic [6:0]  in_ring_index;

  logic               out_valid;
  logic               out_stall;
  logic               out_keep;
  logic signed [24:0] out_x_pos;
  logic signed [24:0] out_y_pos;
  logic signed [24:0] out_z_pos;
  logic [15:0]        out_intensity_out;
  logic [6:0]         out_ring_out;

  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  // one expected point word
  typedef struct packed {
    logic               keep;
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic signed [24:0] z;
    logic [15:0]        intensity;
    logic [6:0]         ring;
  } point_t;

  point_t pending_points[$];

  // shadow copy of the configuration registers
  logic [15:0] yaw_base, yaw_incr, pitch_base, pitch_incr;
  logic [23:0] range_lo, range_hi;
  logic [15:0] intensity_floor;

  int errors;
  int points_sent;
  int points_seen;
  int points_kept;
  bit sender_gaps;
  bit receiver_gaps;

  lidar_range_to_point_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_range_value    (in_range_value),
    .in_intensity_in   (in_intensity_in),
    .in_column_index   (in_column_index),
    .in_ring_index     (in_ring_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_keep          (out_keep),
    .out_x_pos         (out_x_pos),
    .out_y_pos         (out_y_pos),
    .out_z_pos         (out_z_pos),
    .out_intensity_out (out_intensity_out),
    .out_ring_out      (out_ring_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // fixed-point sine of a binary angle, quarter-wave taylor series through x^15
  function automatic logic signed [16:0] sine_q15(input logic [15:0] ang);
    logic [1:0]  quad;
    logic [13:0] low;
    logic [63:0] t, x, x2, term;
    longint      sum, mag;
    int          k;
    quad = ang[15:14];
    low  = ang[13:0];
    t    = quad[0] ? (64'd16384 - low) : {50'd0, low};
    x    = (t * 64'd13493037705) >> 17;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    mag = (sum + 16384) >>> 15;
    if (mag > 32767) mag = 32767;
    return quad[1] ? 17'(-mag) : 17'(mag);
  endfunction

  function automatic logic signed [16:0] cosine_q15(input logic [15:0] ang);
    return sine_q15(ang + 16'd16384);
  endfunction

  // floor((v + 2^(n-1)) / 2^n); arithmetic shift gives floor for negatives
  function automatic longint round_half_up(input longint v, input int n);
    longint w;
    w = v + (longint'(1) <<< (n - 1));
    return w >>> n;
  endfunction

  // computes the point word for one return under the shadow configuration
  function automatic point_t project_return(input logic [23:0] rng, input logic [15:0] inten,
                                            input logic [10:0] col, input logic [6:0] ring);
    point_t      p;
    logic [15:0] yaw, pitch;
    longint      cp, sp, cy, sy, rc;
    p = '0;
    if (range_lo < rng && rng < range_hi && inten >= intensity_floor &&
        col < NUM_COLUMNS && ring < NUM_RINGS) begin
      yaw   = yaw_base + 16'(yaw_incr * col);
      pitch = pitch_base + 16'(pitch_incr * ring);
      cp = cosine_q15(pitch);
      sp = sine_q15(pitch);
      cy = cosine_q15(yaw);
      sy = sine_q15(yaw);
      rc = longint'(rng) * cp;
      p.keep      = 1'b1;
      p.x         = 25'(round_half_up(rc * cy, 30));
      p.y         = 25'(round_half_up(rc * sy, 30));
      p.z         = 25'(round_half_up(longint'(rng) * sp, 15));
      p.intensity = inten;
      p.ring      = ring;
    end
    return p;
  endfunction

  // writes one register and mirrors it into the shadow copy
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_H_ANGLE_MIN:   yaw_base        = value[15:0];
      REG_H_ANGLE_STEP:  yaw_incr        = value[15:0];
      REG_V_ANGLE_MIN:   pitch_base      = value[15:0];
      REG_V_ANGLE_STEP:  pitch_incr      = value[15:0];
      REG_MIN_RANGE:     range_lo        = value;
      REG_MAX_RANGE:     range_hi        = value;
      REG_INTEN_FLOOR:   intensity_floor = value[15:0];
      default: ;
    endcase
  endtask

  // unknown index: the block ignores it, so the shadow stays as it is
  task automatic write_unknown_reg(input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= UNKNOWN_REG;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] hmin, input logic [15:0] hstep,
                                input logic [15:0] vmin, input logic [15:0] vstep,
                                input logic [23:0] rlo, input logic [23:0] rhi,
                                input logic [15:0] imin);
    write_reg(REG_H_ANGLE_MIN, {8'd0, hmin});
    write_reg(REG_H_ANGLE_STEP, {8'd0, hstep});
    write_reg(REG_V_ANGLE_MIN, {8'd0, vmin});
    write_reg(REG_V_ANGLE_STEP, {8'd0, vstep});
    write_reg(REG_MIN_RANGE, rlo);
    write_reg(REG_MAX_RANGE, rhi);
    write_reg(REG_INTEN_FLOOR, {8'd0, imin});
  endtask

  // sends one return word, with an optional random gap in front of it;
  // valid stays high after acceptance so back to back words need no gap
  task automatic send_return(input logic [23:0] rng, input logic [15:0] inten,
                             input logic [10:0] col, input logic [6:0] ring);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_range_value  <= rng;
    in_intensity_in <= inten;
    in_column_index <= col;
    in_ring_index   <= ring;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points = {pending_points, project_return(rng, inten, col, ring)};
    points_sent++;
  endtask

  // drops valid, waits for every expected word, then for the pipeline to settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_range();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 255));
      1: return 24'hFFFFFF - 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  // extremes of every field, the empty window and indexes at the edges
  task automatic test_directed_extremes();
    write_all_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 24'd0, 24'hFFFFFF, 16'd0);
    send_return(24'd0, 16'd0, 11'd0, 7'd0);
    send_return(24'd1, 16'hFFFF, 11'd2047, 7'd127);
    send_return(24'hFFFFFE, 16'hFFFF, 11'd0, 7'd0);
    send_return(24'hFFFFFF, 16'h1234, 11'd5, 7'd3);
    send_return(24'h555555, 16'hAAAA, 11'h555, 7'h55);
    send_return(24'hAAAAAA, 16'h5555, 11'h2AA, 7'h2A);
    drain_pipeline();
    // quadrant boundaries of the sine, quarter-turn steps
    write_all_regs(16'h0000, 16'h4000, 16'hC000, 16'h4000, 24'd0, 24'hFFFFFF, 16'd0);
    for (int c = 0; c < 4; c++) send_return(24'hFFFFFE, 16'd7, 11'(c), 7'(c));
    drain_pipeline();
    // range window bounds exclusive, intensity floor inclusive
    write_all_regs(16'h2000, 16'h0001, 16'hF000, 16'h0010, 24'd1000, 24'd2000, 16'd500);
    send_return(24'd1000, 16'd600, 11'd1, 7'd1);
    send_return(24'd1001, 16'd500, 11'd1, 7'd1);
    send_return(24'd1999, 16'd499, 11'd1, 7'd1);
    send_return(24'd1999, 16'hFFFF, 11'd1, 7'd1);
    send_return(24'd2000, 16'd600, 11'd1, 7'd1);
    drain_pipeline();
    // empty window: max equals min plus one
    write_reg(REG_MAX_RANGE, 24'd1001);
    write_unknown_reg(24'hFFFFFF);
    send_return(24'd1000, 16'hFFFF, 11'd0, 7'd0);
    send_return(24'd1001, 16'hFFFF, 11'd0, 7'd0);
    drain_pipeline();
    write_reg(REG_MAX_RANGE, 24'd0);
    send_return(24'd5, 16'hFFFF, 11'd0, 7'd0);
    drain_pipeline();
  endtask

  // random returns under a random configuration, with idling on both sides when the gap flags are set
  task automatic test_random_returns(input int count, input bit wide_gates);
    logic [23:0] lo, hi;
    lo = wide_gates ? 24'($urandom_range(0, 3)) : pick_range();
    hi = wide_gates ? 24'hFFFFFF - 24'($urandom_range(0, 3)) : pick_range();
    write_all_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   lo, hi, wide_gates ? 16'($urandom_range(0, 255)) : 16'($urandom));
    for (int i = 0; i < count; i++)
      send_return(pick_range(), 16'($urandom), 11'($urandom), 7'($urandom));
    drain_pipeline();
  endtask

  // random receiver stalls in bursts, switched off for the final part
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compares each accepted point word with the oldest expected one
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: point word with none expected (keep %0b x %0d)",
                 $time, out_keep, out_x_pos);
      end else begin
        want = pending_points.pop_front();
        if (want.keep) points_kept++;
        if (out_keep !== want.keep) begin
          errors++;
          $display("%0t: keep expected %0b actual %0b", $time, want.keep, out_keep);
        end
        if (out_x_pos !== want.x) begin
          errors++;
          $display("%0t: x_pos expected %0d actual %0d", $time, want.x, out_x_pos);
        end
        if (out_y_pos !== want.y) begin
          errors++;
          $display("%0t: y_pos expected %0d actual %0d", $time, want.y, out_y_pos);
        end
        if (out_z_pos !== want.z) begin
          errors++;
          $display("%0t: z_pos expected %0d actual %0d", $time, want.z, out_z_pos);
        end
        if (out_intensity_out !== want.intensity) begin
          errors++;
          $display("%0t: intensity_out expected %0d actual %0d",
                   $time, want.intensity, out_intensity_out);
        end
        if (out_ring_out !== want.ring) begin
          errors++;
          $display("%0t: ring_out expected %0d actual %0d", $time, want.ring, out_ring_out);
        end
      end
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    errors          = 0;
    points_sent     = 0;
    points_seen     = 0;
    points_kept     = 0;
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_range_value  = '0;
    in_intensity_in = '0;
    in_column_index = '0;
    in_ring_index   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_H_ANGLE_MIN;
    cfg_data        = '0;
    // shadow mirrors the reset values
    yaw_base = '0; yaw_incr = '0; pitch_base = '0; pitch_incr = '0;
    range_lo = '0; range_hi = 24'hFFFFFF; intensity_floor = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration first, then the directed set
    send_return(24'h000100, 16'd1, 11'd0, 7'd0);
    drain_pipeline();
    test_directed_extremes();

    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    for (int ph = 0; ph < 5; ph++) test_random_returns(60, 1'b1);
    for (int ph = 0; ph < 2; ph++) test_random_returns(40, 1'b0);
    // last part back to back with no idling
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    test_random_returns(50, 1'b1);

    $display("run covered %0d returns over several register settings, %0d points kept",
             points_sent, points_kept);
    $display("%0d point words checked, %0d mismatches", points_seen, errors);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[lidar_range_to_point_converter.f]
+incdir+hdl
hdl/lrpc_pkg.sv
hdl/lrpc_taylor_cell.sv
hdl/lrpc_sine.sv
hdl/lidar_range_to_point_converter.sv
tb/sv/tb_top.sv
